[src/csrb_pkg.sv]
// csrb_pkg: shared constants and types of the sprite region blitter
// used by csrb_cfg, csrb_clip, clipped_sprite_region_blitter_top and csrb_checker
`default_nettype none

package csrb_pkg;

    localparam int MAX_FRAME_DIM  = 512;
    localparam int MAX_SOURCE_DIM = 1024;

    // fixed field widths
    localparam int DIM_W      = 10;
    localparam int STRIDE_W   = 11;
    localparam int POS_W      = 13;
    localparam int SRC_POS_W  = 11;
    localparam int DEST_W     = 12;
    localparam int COLOR_W    = 8;
    localparam int FADDR_W    = 18;
    localparam int SADDR_W    = 20;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    // frame rows that can be inside the frame
    localparam int ROW_W = $clog2(MAX_FRAME_DIM);

    localparam logic [COLOR_W-1:0] TRANSPARENT_INDEX = 8'd255;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANSLATE_X   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANSLATE_Y   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_STRIDE = 3'd4;

    localparam logic FUNC_BEGIN = 1'b0;
    localparam logic FUNC_PIXEL = 1'b1;

    // configuration as seen by the datapath, sizes already saturated
    typedef struct packed {
        logic [DIM_W-1:0]    frame_width;
        logic [DIM_W-1:0]    frame_height;
        logic [DIM_W-1:0]    translate_x;
        logic [DIM_W-1:0]    translate_y;
        logic [STRIDE_W-1:0] source_stride;
    } t_cfg;

    // framebuffer write of one pixel
    typedef struct packed {
        logic               we;
        logic [FADDR_W-1:0] addr;
        logic [COLOR_W-1:0] color;
    } t_wr;

endpackage

`default_nettype wire

[src/csrb_cfg.sv]
// csrb_cfg: configuration registers of the blitter with size saturation
// depends on csrb_pkg
`default_nettype none

module csrb_cfg (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [csrb_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [csrb_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output csrb_pkg::t_cfg                        o_cfg
);
    import csrb_pkg::*;

    logic [DIM_W-1:0]    r_frame_width;
    logic [DIM_W-1:0]    r_frame_height;
    logic [DIM_W-1:0]    r_translate_x;
    logic [DIM_W-1:0]    r_translate_y;
    logic [STRIDE_W-1:0] r_source_stride;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width   <= 10'd320;
            r_frame_height  <= 10'd240;
            r_translate_x   <= '0;
            r_translate_y   <= '0;
            r_source_stride <= 11'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FRAME_WIDTH:   r_frame_width   <= i_cfg_data[DIM_W-1:0];
                CFG_FRAME_HEIGHT:  r_frame_height  <= i_cfg_data[DIM_W-1:0];
                CFG_TRANSLATE_X:   r_translate_x   <= i_cfg_data[DIM_W-1:0];
                CFG_TRANSLATE_Y:   r_translate_y   <= i_cfg_data[DIM_W-1:0];
                CFG_SOURCE_STRIDE: r_source_stride <= i_cfg_data[STRIDE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        o_cfg.frame_width   = (int'(r_frame_width) > MAX_FRAME_DIM) ?
                              DIM_W'(MAX_FRAME_DIM) : r_frame_width;
        o_cfg.frame_height  = (int'(r_frame_height) > MAX_FRAME_DIM) ?
                              DIM_W'(MAX_FRAME_DIM) : r_frame_height;
        o_cfg.translate_x   = r_translate_x;
        o_cfg.translate_y   = r_translate_y;
        o_cfg.source_stride = (int'(r_source_stride) > MAX_SOURCE_DIM) ?
                              STRIDE_W'(MAX_SOURCE_DIM) : r_source_stride;
    end

endmodule

`default_nettype wire

[src/csrb_clip.sv]
// csrb_clip: clip test and framebuffer address of the current target pixel
// depends on csrb_pkg
`default_nettype none

module csrb_clip (
    input  wire csrb_pkg::t_cfg                i_cfg,
    input  wire logic [csrb_pkg::POS_W-1:0]    i_col,
    input  wire logic [csrb_pkg::POS_W-1:0]    i_row,
    input  wire logic [csrb_pkg::COLOR_W-1:0]  i_color,
    output csrb_pkg::t_wr                      o_wr
);
    import csrb_pkg::*;

    logic               w_inside;
    logic [ROW_W+9:0]   w_prod;
    logic [ROW_W+9:0]   w_sum;

    // sign bit clear means column and row are not negative
    assign w_inside = !i_col[POS_W-1] && !i_row[POS_W-1] &&
                      (12'(i_cfg.frame_width) > i_col[POS_W-2:0]) &&
                      (12'(i_cfg.frame_height) > i_row[POS_W-2:0]);

    assign w_prod = (ROW_W+10)'(i_row[ROW_W-1:0]) * (ROW_W+10)'(i_cfg.frame_width);
    assign w_sum  = w_prod + (ROW_W+10)'(i_col[DIM_W-1:0]);

    always_comb begin
        o_wr.we    = w_inside && (i_color != TRANSPARENT_INDEX);
        o_wr.addr  = o_wr.we ? FADDR_W'(w_sum) : '0;
        o_wr.color = o_wr.we ? i_color : '0;
    end

endmodule

`default_nettype wire

[src/clipped_sprite_region_blitter_top.sv]
// clipped_sprite_region_blitter_top: sprite region blitter with color key and clipping
// depends on csrb_pkg, csrb_cfg and csrb_clip
//
// usage:
//   input channel (i_in_valid / o_in_stall): func 0 is a begin item carrying the
//   source region, destination origin and flip flag; func 1 is a pixel item
//   carrying one color index. output channel (o_out_valid / i_out_stall)
//   carries one result per begin item and per pixel item of an active region.
//   a begin item answers with the source address of the first pixel, or with
//   last set when the region is empty. a pixel item answers with the
//   framebuffer write (write_enable low for color 255 or off-frame targets),
//   the source address of the next pixel and last on the final pixel.
//   pixel items while idle are taken and give no result.
//   result: registered, and shown in the cycle after acceptance.
//   throughput: one item per cycle while no result is stalled; the region walk
//   state, one clip/address unit and one source address multiplier all settle
//   within that cycle. the result register holds while i_out_stall is high,
//   and o_in_stall is raised only while a result is waiting and stalled.
//   reset: synchronous active low; the block is idle and the configuration
//   registers return to 320x240 frame, no translation, source stride 1.
//   configuration is written through i_cfg_we / i_cfg_index / i_cfg_data
//   while the block is idle.
`default_nettype none

module clipped_sprite_region_blitter_top (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_cfg_we,
    input  wire logic [csrb_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [csrb_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  wire logic                                   i_in_valid,
    output logic                                        o_in_stall,
    input  wire logic                                   i_func,
    input  wire logic [csrb_pkg::DIM_W-1:0]             i_src_x,
    input  wire logic [csrb_pkg::DIM_W-1:0]             i_src_y,
    input  wire logic [csrb_pkg::DIM_W-1:0]             i_region_width,
    input  wire logic [csrb_pkg::DIM_W-1:0]             i_region_height,
    input  wire logic signed [csrb_pkg::DEST_W-1:0]     i_dest_x,
    input  wire logic signed [csrb_pkg::DEST_W-1:0]     i_dest_y,
    input  wire logic                                   i_flip,
    input  wire logic [csrb_pkg::COLOR_W-1:0]           i_color_index,
    output logic                                        o_out_valid,
    input  wire logic                                   i_out_stall,
    output logic                                        o_write_enable,
    output logic [csrb_pkg::FADDR_W-1:0]                o_frame_address,
    output logic [csrb_pkg::COLOR_W-1:0]                o_color_out,
    output logic [csrb_pkg::SADDR_W-1:0]                o_source_address,
    output logic                                        o_last
);
    import csrb_pkg::*;

    t_cfg w_cfg;
    t_wr  w_wr;

    // region walk state
    logic                 r_active, n_active;
    logic [POS_W-1:0]     r_dest_col, n_dest_col;
    logic [POS_W-1:0]     r_dest_row, n_dest_row;
    logic [POS_W-1:0]     r_row_start_col, n_row_start_col;
    logic                 r_col_step_neg, n_col_step_neg;
    logic [DIM_W-1:0]     r_cols_left, n_cols_left;
    logic [DIM_W-1:0]     r_rows_left, n_rows_left;
    logic [DIM_W-1:0]     r_saved_width, n_saved_width;
    logic [SRC_POS_W-1:0] r_source_col, n_source_col;
    logic [SRC_POS_W-1:0] r_source_row, n_source_row;
    logic [DIM_W-1:0]     r_source_left, n_source_left;

    // result register
    logic                 r_out_valid;
    logic                 r_we;
    logic [FADDR_W-1:0]   r_faddr;
    logic [COLOR_W-1:0]   r_color;
    logic [SADDR_W-1:0]   r_saddr;
    logic                 r_last;

    logic                 w_in_acc;
    logic                 w_begin;
    logic                 w_step;
    logic                 w_row_end;
    logic                 w_done;
    logic                 w_res_last;
    logic [POS_W-1:0]     w_dx;
    logic [POS_W-1:0]     w_dy;
    logic [21:0]          w_sprod;
    logic [21:0]          w_ssum;
    logic [SADDR_W-1:0]   w_saddr;

    csrb_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    csrb_clip u_clip (
        .i_cfg   (w_cfg),
        .i_col   (r_dest_col),
        .i_row   (r_dest_row),
        .i_color (i_color_index),
        .o_wr    (w_wr)
    );

    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_begin    = (i_func == FUNC_BEGIN);
    assign w_step     = w_in_acc && (w_begin || r_active);

    assign w_dx = POS_W'($signed(i_dest_x)) + POS_W'($signed(w_cfg.translate_x));
    assign w_dy = POS_W'($signed(i_dest_y)) + POS_W'($signed(w_cfg.translate_y));

    assign w_row_end = (r_cols_left == 10'd1);
    assign w_done    = w_row_end && (r_rows_left == 10'd1);

    always_comb begin
        n_active        = r_active;
        n_dest_col      = r_dest_col;
        n_dest_row      = r_dest_row;
        n_row_start_col = r_row_start_col;
        n_col_step_neg  = r_col_step_neg;
        n_cols_left     = r_cols_left;
        n_rows_left     = r_rows_left;
        n_saved_width   = r_saved_width;
        n_source_col    = r_source_col;
        n_source_row    = r_source_row;
        n_source_left   = r_source_left;
        if (w_begin) begin
            n_active        = (i_region_width != '0) && (i_region_height != '0);
            n_col_step_neg  = i_flip;
            n_row_start_col = i_flip ? w_dx + POS_W'(i_region_width) - 13'd1 : w_dx;
            n_dest_col      = n_row_start_col;
            n_dest_row      = w_dy;
            n_cols_left     = i_region_width;
            n_saved_width   = i_region_width;
            n_rows_left     = i_region_height;
            n_source_left   = i_src_x;
            n_source_col    = SRC_POS_W'(i_src_x);
            n_source_row    = SRC_POS_W'(i_src_y);
        end else if (w_row_end) begin
            n_active     = !w_done;
            n_rows_left  = r_rows_left - 10'd1;
            n_dest_row   = r_dest_row + 13'd1;
            n_dest_col   = r_row_start_col;
            n_source_col = SRC_POS_W'(r_source_left);
            n_source_row = r_source_row + 11'd1;
            n_cols_left  = r_saved_width;
        end else begin
            n_cols_left  = r_cols_left - 10'd1;
            n_source_col = r_source_col + 11'd1;
            n_dest_col   = r_col_step_neg ? r_dest_col - 13'd1 : r_dest_col + 13'd1;
        end
    end

    // source address of the next pixel
    assign w_sprod = 22'(n_source_row) * 22'(w_cfg.source_stride);
    assign w_ssum  = w_sprod + 22'(n_source_col);

    assign w_res_last = w_begin ? !n_active : w_done;
    assign w_saddr    = w_res_last ? '0 : w_ssum[SADDR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_step) begin
                r_active <= n_active;
            end
            if (w_in_acc) begin
                r_out_valid <= w_step;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_dest_col      <= n_dest_col;
            r_dest_row      <= n_dest_row;
            r_row_start_col <= n_row_start_col;
            r_col_step_neg  <= n_col_step_neg;
            r_cols_left     <= n_cols_left;
            r_rows_left     <= n_rows_left;
            r_saved_width   <= n_saved_width;
            r_source_col    <= n_source_col;
            r_source_row    <= n_source_row;
            r_source_left   <= n_source_left;
            r_we            <= w_begin ? 1'b0 : w_wr.we;
            r_faddr         <= w_begin ? '0 : w_wr.addr;
            r_color         <= w_begin ? '0 : w_wr.color;
            r_saddr         <= w_saddr;
            r_last          <= w_res_last;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_write_enable   = r_we;
    assign o_frame_address  = r_faddr;
    assign o_color_out      = r_color;
    assign o_source_address = r_saddr;
    assign o_last           = r_last;

endmodule

`default_nettype wire

[src/csrb_checker.sv]
// csrb_checker: port-level assertions of the sprite region blitter, bound to the top level
// depends on csrb_pkg and clipped_sprite_region_blitter_top
`default_nettype none

module csrb_checker (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_in_valid,
    input  wire logic                                   o_in_stall,
    input  wire logic                                   i_func,
    input  wire logic                                   o_out_valid,
    input  wire logic                                   i_out_stall,
    input  wire logic                                   o_write_enable,
    input  wire logic [csrb_pkg::FADDR_W-1:0]           o_frame_address,
    input  wire logic [csrb_pkg::COLOR_W-1:0]           o_color_out,
    input  wire logic [csrb_pkg::SADDR_W-1:0]           o_source_address,
    input  wire logic                                   o_last
);
    import csrb_pkg::*;

    // input side stalls only behind a held result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a held result");

    // every accepted begin item gives a result next cycle
    a_begin_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_func == FUNC_BEGIN)) |=> o_out_valid)
        else $error("begin item gave no result");

    // suppressed write carries zero address and color
    a_no_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_write_enable) |->
        ((o_frame_address == '0) && (o_color_out == '0)))
        else $error("suppressed write with nonzero payload");

    // transparent color is never written, finished region fetches nothing
    a_key_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!(o_write_enable && (o_color_out == TRANSPARENT_INDEX)) &&
                         !(o_last && (o_source_address != '0))))
        else $error("transparent write or fetch after last");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
        (o_out_valid && $stable(o_write_enable) && $stable(o_frame_address) &&
         $stable(o_color_out) && $stable(o_source_address) && $stable(o_last)))
        else $error("stalled result changed");

endmodule

bind clipped_sprite_region_blitter_top csrb_checker u_csrb_checker (.*);

`default_nettype wire
